@@ design/fpr_pkg.sv @@
// ----------------------------------------------------------------------------
// fpr_pkg: shared types and codes of the frame packet reassembler
// Status codes and fixed field widths.
// ----------------------------------------------------------------------------
package fpr_pkg;

   typedef enum logic [2:0] {
      ST_INFO_OK    = 3'd0,
      ST_WRITTEN    = 3'd1,
      ST_SIZE_ERR   = 3'd2,
      ST_UNKNOWN    = 3'd3,
      ST_BAD_ID     = 3'd4,
      ST_BOUNDS     = 3'd5,
      ST_INFO_REJ   = 3'd6
   } status_type;

   localparam int ADDR_W  = 21;
   localparam int CHUNK_W = 11;
   localparam logic [CHUNK_W-1:0] CHUNK_RESET = 11'd1400;

endpackage

@@ design/frame_packet_reassembler_core.sv @@
// ----------------------------------------------------------------------------
// frame_packet_reassembler_core
// Reassembles frames from numbered packets into fixed-size memory slots.
// ----------------------------------------------------------------------------
// One word is worked on at a time. Each word spends its accept cycle in idle
// and an output phase that loads the result register. A word in between
// passes straight from idle to the output phase: a rejected frame-info word,
// or a later beat of a packet already under way.
// The first beat of a packet reads the received-map memory, whose read is
// registered. It then checks the word and forms the packet offset
// (idx * chunk_bytes), and then runs the bounds compare before the output
// phase. An accepted frame-info word clears its slot's map rows by a sweep
// of MW rows before the output phase. A new word can be accepted while an
// earlier result still waits in the output register. The output phase
// holds until that result is taken.
// chunk_bytes is to be written through csr_write_enable / csr_write_data
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module frame_packet_reassembler_core
   import fpr_pkg::*;
#(
   parameter int FRAME_SLOTS = 4,
   parameter int MAX_PACKETS = 256,
   parameter int SLOT_BYTES  = 524288,
   parameter int BEAT_BYTES  = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [10:0]  csr_write_data,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_type,
   input  logic [31:0]  req_frame_id,
   input  logic [23:0]  req_total_size,
   input  logic [15:0]  req_packet_count,
   input  logic [15:0]  req_frame_width,
   input  logic [15:0]  req_frame_height,
   input  logic [15:0]  req_packet_index,
   input  logic [10:0]  req_declared_size,
   input  logic [10:0]  req_payload_len,
   input  logic [63:0]  req_payload_word,
   input  logic         req_payload_last,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [2:0]   rsp_status,
   output logic         rsp_write_enable,
   output logic [20:0]  rsp_write_addr,
   output logic [63:0]  rsp_write_data,
   output logic [3:0]   rsp_write_bytes,
   output logic         rsp_frame_done,
   output logic [31:0]  rsp_done_frame_id,
   output logic [1:0]   rsp_done_slot,
   output logic [15:0]  rsp_done_width,
   output logic [15:0]  rsp_done_height,
   output logic [19:0]  rsp_done_size
);

   localparam int SW  = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
   localparam int MW  = (MAX_PACKETS + 63) / 64;
   localparam int MWW = (MW > 1) ? $clog2(MW) : 1;
   localparam int PW  = $clog2(MAX_PACKETS + 1);
   localparam int BW  = $clog2(BEAT_BYTES + 1);
   localparam int MAPD = FRAME_SLOTS * MW;
   localparam int MAW = (MAPD > 1) ? $clog2(MAPD) : 1;
   localparam int OFW = 16 + CHUNK_W;

   typedef enum logic [2:0] {
      P_IDLE, P_CLEAR, P_READ, P_CHECK, P_BOUND, P_OUT
   } phase_type;

   phase_type phase_ff, phase_in;

   logic [CHUNK_W-1:0] chunk_ff;
   logic [FRAME_SLOTS-1:0] valid_ff;
   logic [31:0] tag_ff   [FRAME_SLOTS];
   logic [19:0] size_ff  [FRAME_SLOTS];
   logic [PW-1:0] total_ff [FRAME_SLOTS];
   logic [PW-1:0] seen_ff  [FRAME_SLOTS];
   logic [31:0] dims_ff  [FRAME_SLOTS];
   logic [SW-1:0] alloc_ff;
   logic          inprog_ff;
   logic [2:0]    verdict_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [10:0]   remain_ff;
   logic [SW-1:0] pslot_ff;

   // received map memory
   logic [63:0]   map_mem [MAPD];
   logic [63:0]   map_rd_ff;
   logic          map_we;
   logic [MAW-1:0] map_wa, map_ra;
   logic [63:0]   map_wd;

   // latched input word
   logic        h_type;
   logic [31:0] h_id;
   logic [15:0] h_idx;
   logic [10:0] h_decl, h_len;
   logic [63:0] h_word;
   logic        h_last;
   logic [SW-1:0] h_slot;
   logic          h_hit;
   logic [MWW-1:0] clr_ff;
   logic [SW-1:0]  clr_slot_ff;
   logic [OFW-1:0] off_ff;

   // output register
   logic        ov_ff;
   logic [2:0]  o_status;
   logic        o_we;
   logic [20:0] o_addr;
   logic [63:0] o_data;
   logic [3:0]  o_bytes;
   logic        o_done;
   logic [31:0] o_id;
   logic [1:0]  o_slot;
   logic [15:0] o_w, o_h;
   logic [19:0] o_size;

   wire accept = req_valid && req_ready;
   wire out_free = !ov_ff || rsp_ready;
   assign req_ready = (phase_ff == P_IDLE);

   // tag search
   logic [SW-1:0] find_s;
   logic          find_hit;
   always_comb begin
      find_s = '0;
      find_hit = 1'b0;
      for (int s = FRAME_SLOTS - 1; s >= 0; s--) begin
         if (valid_ff[s] && tag_ff[s] == req_frame_id) begin
            find_s = SW'(s);
            find_hit = 1'b1;
         end
      end
   end

   // circular search for a free slot from alloc pointer
   logic [SW-1:0] free_s;
   always_comb begin
      logic [SW:0] c;
      free_s = alloc_ff;
      for (int k = FRAME_SLOTS - 1; k >= 0; k--) begin
         c = (SW+1)'(alloc_ff) + (SW+1)'(k);
         if (c >= (SW+1)'(FRAME_SLOTS)) c = c - (SW+1)'(FRAME_SLOTS);
         if (!valid_ff[c[SW-1:0]]) free_s = c[SW-1:0];
      end
   end

   wire info_rej = (req_total_size > 24'(SLOT_BYTES)) ||
                   ({1'b0, req_packet_count} > 17'(MAX_PACKETS));
   wire [SW-1:0] info_s = find_hit ? find_s : free_s;

   function automatic logic [MAW-1:0] map_index(input logic [SW-1:0] s,
                                                input logic [MWW-1:0] w);
      logic [31:0] v;
      v = 32'(s) * 32'(MW) + 32'(w);
      return v[MAW-1:0];
   endfunction

   wire [MWW-1:0] idx_word = MWW'(h_idx >> 6);

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_wa] <= map_wd;
      map_rd_ff <= map_mem[map_ra];
   end

   // check stage values
   wire idx_bad = ({16'd0, h_idx} >= 32'(total_ff[h_slot])) ||
                  ({16'd0, h_idx} >= 32'(MAX_PACKETS)) || map_rd_ff[h_idx[5:0]];

   // packet end lies past the stored frame size
   wire bound_bad = (32'(off_ff) + 32'(h_len)) > 32'(size_ff[h_slot]);

   logic [BW-1:0] wb;
   always_comb begin
      wb = (remain_ff < 11'(BEAT_BYTES)) ? BW'(remain_ff) : BW'(BEAT_BYTES);
   end

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         P_IDLE: begin
            if (accept) begin
               if (!req_type) phase_in = info_rej ? P_OUT : P_CLEAR;
               else if (!inprog_ff) phase_in = P_READ;
               else phase_in = P_OUT;
            end
         end
         P_CLEAR: if (32'(clr_ff) == MW - 1) phase_in = P_OUT;
         P_READ:  phase_in = P_CHECK;
         P_CHECK: phase_in = P_BOUND;
         P_BOUND: phase_in = P_OUT;
         P_OUT:   if (out_free) phase_in = P_IDLE;
         default: phase_in = P_IDLE;
      endcase
   end

   always_comb begin
      map_we = 1'b0;
      map_wa = map_index(clr_slot_ff, clr_ff);
      map_wd = '0;
      map_ra = map_index(h_slot, idx_word);
      if (phase_ff == P_CLEAR) map_we = 1'b1;
      if (phase_ff == P_BOUND && verdict_ff == ST_WRITTEN && !bound_bad) begin
         map_we = 1'b1;
         map_wa = map_index(h_slot, idx_word);
         map_wd = map_rd_ff | (64'd1 << h_idx[5:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= P_IDLE;
         chunk_ff   <= CHUNK_RESET;
         valid_ff   <= '0;
         alloc_ff   <= '0;
         inprog_ff  <= 1'b0;
         verdict_ff <= '0;
         addr_ff    <= '0;
         remain_ff  <= '0;
         pslot_ff   <= '0;
         ov_ff      <= 1'b0;
         clr_ff     <= '0;
      end else begin
         phase_ff <= phase_in;
         if (csr_write_enable) chunk_ff <= csr_write_data;
         // load a new result or drop the one just taken
         if (phase_ff == P_OUT && out_free) ov_ff <= 1'b1;
         else if (rsp_ready) ov_ff <= 1'b0;
         unique case (phase_ff)
            P_IDLE: if (accept) begin
               clr_ff <= '0;
               if (!req_type) begin
                  inprog_ff <= 1'b0;
                  if (!info_rej) begin
                     if (!find_hit) begin
                        alloc_ff <= (32'(info_s) == FRAME_SLOTS - 1) ? '0 : info_s + 1'b1;
                     end
                     clr_slot_ff <= info_s;
                  end
               end else if (!inprog_ff) begin
                  inprog_ff <= 1'b1;
                  remain_ff <= '0;
                  addr_ff   <= '0;
               end
            end
            P_CLEAR: clr_ff <= clr_ff + 1'b1;
            P_CHECK: begin
               off_ff <= OFW'(h_idx) * OFW'(chunk_ff);
               if (h_decl != h_len) verdict_ff <= ST_SIZE_ERR;
               else if (!h_hit) verdict_ff <= ST_UNKNOWN;
               else if (idx_bad) verdict_ff <= ST_BAD_ID;
               else verdict_ff <= ST_WRITTEN;
            end
            P_BOUND: begin
               if (verdict_ff == ST_WRITTEN) begin
                  if (bound_bad) begin
                     verdict_ff <= ST_BOUNDS;
                  end else begin
                     pslot_ff  <= h_slot;
                     seen_ff[h_slot] <= seen_ff[h_slot] + 1'b1;
                     remain_ff <= h_len;
                     addr_ff   <= ADDR_W'(32'(h_slot) * 32'(SLOT_BYTES) + 32'(off_ff));
                  end
               end
            end
            P_OUT: if (out_free) begin
               if (h_type) begin
                  if (verdict_ff == ST_WRITTEN && wb != '0) begin
                     addr_ff <= addr_ff + ADDR_W'(wb);
                  end
                  if (h_last) begin
                     inprog_ff <= 1'b0;
                     remain_ff <= '0;
                     if (verdict_ff == ST_WRITTEN && valid_ff[pslot_ff] &&
                         seen_ff[pslot_ff] == total_ff[pslot_ff])
                        valid_ff[pslot_ff] <= 1'b0;
                  end else if (verdict_ff == ST_WRITTEN && wb != '0) begin
                     remain_ff <= remain_ff - 11'(wb);
                  end
               end
            end
            default: ;
         endcase
         // slot registers written at the end of a clearing sweep
         if (phase_ff == P_CLEAR && 32'(clr_ff) == MW - 1) begin
            valid_ff[clr_slot_ff] <= 1'b1;
            seen_ff[clr_slot_ff]  <= '0;
         end
      end
   end

   // payload registers
   logic info_rej_ff;
   logic [23:0] h_size;
   logic [15:0] h_count, h_w, h_hh;
   always_ff @(posedge clock) begin
      if (accept) begin
         h_type  <= req_type;
         h_id    <= req_frame_id;
         h_idx   <= req_packet_index;
         h_decl  <= req_declared_size;
         h_len   <= req_payload_len;
         h_word  <= req_payload_word;
         h_last  <= req_payload_last;
         h_slot  <= find_s;
         h_hit   <= find_hit;
         h_size  <= req_total_size;
         h_count <= req_packet_count;
         h_w     <= req_frame_width;
         h_hh    <= req_frame_height;
         info_rej_ff <= info_rej;
      end
      if (phase_ff == P_CLEAR && 32'(clr_ff) == MW - 1) begin
         tag_ff[clr_slot_ff]   <= h_id;
         size_ff[clr_slot_ff]  <= h_size[19:0];
         total_ff[clr_slot_ff] <= PW'(h_count);
         dims_ff[clr_slot_ff]  <= {h_hh, h_w};
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (phase_ff == P_OUT && out_free) begin
         o_we <= 1'b0; o_addr <= '0; o_data <= '0; o_bytes <= '0;
         o_done <= 1'b0; o_id <= '0; o_slot <= '0; o_w <= '0; o_h <= '0;
         o_size <= '0;
         if (!h_type) begin
            o_status <= info_rej_ff ? ST_INFO_REJ : ST_INFO_OK;
         end else begin
            o_status <= verdict_ff;
            if (verdict_ff == ST_WRITTEN && wb != '0) begin
               o_we <= 1'b1; o_addr <= addr_ff; o_data <= h_word;
               o_bytes <= 4'(wb);
            end
            if (h_last && verdict_ff == ST_WRITTEN && valid_ff[pslot_ff] &&
                seen_ff[pslot_ff] == total_ff[pslot_ff]) begin
               o_done <= 1'b1;
               o_id   <= tag_ff[pslot_ff];
               o_slot <= 2'(pslot_ff);
               o_w    <= dims_ff[pslot_ff][15:0];
               o_h    <= dims_ff[pslot_ff][31:16];
               o_size <= size_ff[pslot_ff];
            end
         end
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_status = o_status;
   assign rsp_write_enable = o_we;
   assign rsp_write_addr = o_addr;
   assign rsp_write_data = o_data;
   assign rsp_write_bytes = o_bytes;
   assign rsp_frame_done = o_done;
   assign rsp_done_frame_id = o_id;
   assign rsp_done_slot = o_slot;
   assign rsp_done_width = o_w;
   assign rsp_done_height = o_h;
   assign rsp_done_size = o_size;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != P_IDLE) |-> !req_ready) else $error("accept while busy");
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_write_data)))
      else $error("result changed while waiting");
   a_done_written: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && o_done) |-> (o_status == ST_WRITTEN)) else $error("done on bad packet");

endmodule

@@ sim/tb_frame_packet_reassembler_core.sv @@
// ----------------------------------------------------------------------------
// tb_frame_packet_reassembler_core
// Drives info words and packet beats into the reassembler and checks every
// result word against a predictor of slots, received maps and write commands.
// ----------------------------------------------------------------------------
module tb_frame_packet_reassembler_core;
   import fpr_pkg::*;

   localparam int NSLOT     = 4;
   localparam int MAXPKT    = 256;
   localparam int SLOTB     = 524288;
   localparam int CYC_LIMIT = 2000000;
   localparam int DRAIN     = 40;

   typedef struct packed {
      logic        kind;
      logic [31:0] id;
      logic [23:0] tsize;
      logic [15:0] pcount;
      logic [15:0] wid;
      logic [15:0] hgt;
      logic [15:0] pidx;
      logic [10:0] decl;
      logic [10:0] plen;
      logic [63:0] data;
      logic        last;
   } beat_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        we;
      logic [20:0] waddr;
      logic [63:0] wdata;
      logic [3:0]  wbytes;
      logic        done;
      logic [31:0] did;
      logic [1:0]  dslot;
      logic [15:0] dw;
      logic [15:0] dh;
      logic [19:0] dsize;
   } result_type;

   int error_count = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   // Reassembly predictor plus the queue of results it has worked out.
   class reassembly_board;
      logic [10:0]  chunk;
      bit           valid_q [NSLOT];
      logic [31:0]  tag_q [NSLOT];
      logic [19:0]  size_q [NSLOT];
      int unsigned  total_q [NSLOT];
      int unsigned  seen_q [NSLOT];
      logic [15:0]  w_q [NSLOT], h_q [NSLOT];
      bit [MAXPKT-1:0] map_q [NSLOT];
      int unsigned  alloc_ptr;
      bit           in_pkt;
      logic [2:0]   verdict;
      logic [20:0]  addr;
      int unsigned  remain;
      int unsigned  pslot;
      result_type   pending[$];

      function new();
         chunk = CHUNK_RESET;
         alloc_ptr = 0; in_pkt = 0; verdict = ST_INFO_OK;
         addr = 0; remain = 0; pslot = 0;
         for (int s = 0; s < NSLOT; s++) begin
            valid_q[s] = 0; map_q[s] = '0;
         end
      endfunction

      function int lookup(logic [31:0] id);
         for (int s = 0; s < NSLOT; s++)
            if (valid_q[s] && tag_q[s] == id) return s;
         return -1;
      endfunction

      function void open_packet(beat_type b);
         int s;
         longint unsigned off;
         in_pkt = 1; remain = 0; addr = 0;
         if (b.decl != b.plen) begin verdict = ST_SIZE_ERR; return; end
         s = lookup(b.id);
         if (s < 0) begin verdict = ST_UNKNOWN; return; end
         if (b.pidx >= total_q[s] || b.pidx >= MAXPKT || map_q[s][b.pidx[7:0]]) begin
            verdict = ST_BAD_ID; return;
         end
         off = longint'(b.pidx) * longint'(chunk);
         if (off + b.plen > size_q[s]) begin verdict = ST_BOUNDS; return; end
         verdict = ST_WRITTEN;
         pslot = s;
         map_q[s][b.pidx[7:0]] = 1;
         seen_q[s]++;
         remain = b.plen;
         addr = 21'(longint'(s) * SLOTB + off);
      endfunction

      // Note an accepted word and queue the result it causes.
      function void note_word(beat_type b);
         result_type r;
         int s;
         int unsigned n;
         r = '0;
         if (b.kind == 1'b0) begin
            in_pkt = 0;
            if (b.tsize > SLOTB || b.pcount > MAXPKT) r.status = ST_INFO_REJ;
            else begin
               s = lookup(b.id);
               if (s < 0) begin
                  s = alloc_ptr;
                  for (int k = 0; k < NSLOT; k++)
                     if (!valid_q[(alloc_ptr + k) % NSLOT]) begin
                        s = (alloc_ptr + k) % NSLOT; break;
                     end
                  alloc_ptr = (s + 1) % NSLOT;
               end
               valid_q[s] = 1; tag_q[s] = b.id; size_q[s] = b.tsize[19:0];
               total_q[s] = b.pcount; seen_q[s] = 0;
               w_q[s] = b.wid; h_q[s] = b.hgt; map_q[s] = '0;
               r.status = ST_INFO_OK;
            end
         end else begin
            if (!in_pkt) open_packet(b);
            r.status = verdict;
            if (verdict == ST_WRITTEN && remain > 0) begin
               n = remain < 8 ? remain : 8;
               r.we = 1; r.waddr = addr; r.wdata = b.data; r.wbytes = 4'(n);
               remain -= n; addr = addr + 21'(n);
            end
            if (b.last) begin
               if (verdict == ST_WRITTEN && valid_q[pslot] &&
                   seen_q[pslot] == total_q[pslot]) begin
                  r.done = 1; r.did = tag_q[pslot]; r.dslot = 2'(pslot);
                  r.dw = w_q[pslot]; r.dh = h_q[pslot]; r.dsize = size_q[pslot];
                  valid_q[pslot] = 0;
               end
               in_pkt = 0; remain = 0;
            end
         end
         pending.push_back(r);
      endfunction

      // Compare a delivered result with the oldest expectation.
      task check_result(result_type got);
         result_type w;
         if (pending.size() == 0) begin
            report_mismatch("unexpected result", got.status, 0);
            return;
         end
         w = pending.pop_front();
         if (got.status !== w.status) report_mismatch("status", got.status, w.status);
         if (got.we !== w.we) report_mismatch("write_enable", got.we, w.we);
         if (got.waddr !== w.waddr) report_mismatch("write_addr", got.waddr, w.waddr);
         if (got.wdata !== w.wdata) report_mismatch("write_data", got.wdata, w.wdata);
         if (got.wbytes !== w.wbytes) report_mismatch("write_bytes", got.wbytes, w.wbytes);
         if (got.done !== w.done) report_mismatch("frame_done", got.done, w.done);
         if (got.did !== w.did) report_mismatch("done_frame_id", got.did, w.did);
         if (got.dslot !== w.dslot) report_mismatch("done_slot", got.dslot, w.dslot);
         if (got.dw !== w.dw) report_mismatch("done_width", got.dw, w.dw);
         if (got.dh !== w.dh) report_mismatch("done_height", got.dh, w.dh);
         if (got.dsize !== w.dsize) report_mismatch("done_size", got.dsize, w.dsize);
      endtask
   endclass

   logic clock = 0, reset = 1;
   logic csr_write_enable = 0;
   logic [10:0] csr_write_data = '0;
   logic req_valid = 0, req_ready;
   beat_type req = '0;
   logic rsp_valid, rsp_ready = 0;
   result_type rsp;
   int send_idle = 0, recv_stall = 0;
   int unsigned cycles = 0;
   reassembly_board board;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   frame_packet_reassembler_core u_top (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_type(req.kind), .req_frame_id(req.id), .req_total_size(req.tsize),
      .req_packet_count(req.pcount), .req_frame_width(req.wid),
      .req_frame_height(req.hgt), .req_packet_index(req.pidx),
      .req_declared_size(req.decl), .req_payload_len(req.plen),
      .req_payload_word(req.data), .req_payload_last(req.last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp.status), .rsp_write_enable(rsp.we),
      .rsp_write_addr(rsp.waddr), .rsp_write_data(rsp.wdata),
      .rsp_write_bytes(rsp.wbytes), .rsp_frame_done(rsp.done),
      .rsp_done_frame_id(rsp.did), .rsp_done_slot(rsp.dslot),
      .rsp_done_width(rsp.dw), .rsp_done_height(rsp.dh), .rsp_done_size(rsp.dsize)
   );

   // Receiver: check at the edge, then decide the stall for the next cycle.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp);
      rsp_ready <= ($urandom_range(99) >= recv_stall);
      if (cycles > CYC_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Present one word, idle first at random, hold until accepted.
   task automatic send_word(input beat_type b);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req <= b;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      board.note_word(b);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_chunk(input logic [10:0] v);
      wait_drained();
      csr_write_enable <= 1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
      board.chunk = v;
   endtask

   function automatic beat_type info_word(logic [31:0] id, logic [23:0] sz,
                                          logic [15:0] cnt);
      beat_type b;
      b = '0;
      b.kind = 0; b.id = id; b.tsize = sz; b.pcount = cnt;
      b.wid = 16'($urandom); b.hgt = 16'($urandom);
      b.pidx = 16'($urandom); b.data = {$urandom, $urandom};
      return b;
   endfunction

   // Send one packet: beats cover the length, sometimes cut short or padded.
   task automatic send_packet(input logic [31:0] id, input logic [15:0] idx,
                              input logic [10:0] len, input logic [10:0] decl);
      beat_type b;
      int nb;
      nb = (len + 7) / 8;
      if (nb == 0) nb = 1;
      case ($urandom_range(9))
         0: nb = $urandom_range(1, nb);
         1: nb = nb + $urandom_range(1, 2);
         default: ;
      endcase
      for (int i = 0; i < nb; i++) begin
         b = '0;
         b.kind = 1; b.id = id; b.pidx = idx; b.decl = decl; b.plen = len;
         b.data = {$urandom, $urandom};
         b.tsize = 24'($urandom); b.pcount = 16'($urandom);
         b.last = (i == nb - 1);
         send_word(b);
      end
   endtask

   // Well-formed frame with random content and occasional damage.
   task automatic send_frame(input logic [31:0] id);
      int cnt, chunk, sz, len, idx;
      chunk = board.chunk;
      cnt = $urandom_range(1, 6);
      if ($urandom_range(30) == 0) cnt = $urandom_range(0, 300);
      sz = cnt * chunk;
      if (sz > SLOTB) sz = SLOTB;
      if ($urandom_range(9) == 0) sz = $urandom_range(0, sz);
      send_word(info_word(id, 24'(sz), 16'(cnt)));
      for (int p = 0; p < cnt && p < 8; p++) begin
         idx = p;
         len = chunk > 40 ? $urandom_range(0, 40) : chunk;
         if ($urandom_range(15) == 0) idx = $urandom_range(0, cnt + 2);
         if ($urandom_range(15) == 0)
            send_packet(id, 16'(idx), 11'(len), 11'(len) ^ 11'($urandom_range(1, 2047)));
         else if ($urandom_range(20) == 0)
            send_packet($urandom, 16'(idx), 11'(len), 11'(len));
         else
            send_packet(id, 16'(idx), 11'(len), 11'(len));
      end
   endtask

   initial begin
      beat_type b;
      board = new();
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, rejects, re-info, size, unknown-id and bad-index errors.
      send_word(info_word(32'hFFFF_FFFF, 24'hFF_FFFF, 16'd2));
      send_word(info_word(32'h0, 24'd0, 16'hFFFF));
      send_word(info_word(32'hFFFF_FFFF, 24'(SLOTB), 16'(MAXPKT)));
      send_packet(32'hFFFF_FFFF, 16'd0, 11'd2036, 11'd2047);
      send_packet(32'h1234, 16'd0, 11'd8, 11'd8);
      send_packet(32'hFFFF_FFFF, 16'hFFFF, 11'd8, 11'd8);
      send_packet(32'hFFFF_FFFF, 16'd255, 11'd2036, 11'd2036);
      send_packet(32'hFFFF_FFFF, 16'd255, 11'd8, 11'd8);
      send_packet(32'hFFFF_FFFF, 16'd3, 11'd0, 11'd0);
      send_word(info_word(32'h55, 24'd100, 16'd0));
      send_packet(32'h55, 16'd0, 11'd4, 11'd4);
      b = info_word(32'hFFFF_FFFF, 24'd2800, 16'd2);
      send_word(b);
      send_packet(32'hFFFF_FFFF, 16'd1, 11'd13, 11'd13);
      send_packet(32'hFFFF_FFFF, 16'd0, 11'd1400, 11'd1400);
      for (int i = 0; i < 5; i++) send_word(info_word(32'h100 + i, 24'd64, 16'd1));
      // Sender holds off until the block has drained.
      wait_drained();

      // Random phases with chunk settings including the extremes.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            1: write_chunk(11'd1);
            2: write_chunk(11'd2036);
            3: write_chunk(11'd0);
            4: write_chunk(11'd2047);
            5: write_chunk(11'($urandom_range(8, 64)));
            6: write_chunk(11'($urandom_range(1, 2036)));
            7: write_chunk(11'd1400);
            default: ;
         endcase
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 62; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 62; end
            default: begin send_idle = 31; recv_stall = 31; end
         endcase
         for (int f = 0; f < 16; f++) begin
            if ($urandom_range(9) == 0) begin
               b = info_word($urandom, 24'($urandom), 16'($urandom));
               b.kind = 1'($urandom); b.last = 1'($urandom);
               b.decl = 11'($urandom); b.plen = 11'($urandom_range(0, 2036));
               send_word(b);
            end else
               send_frame($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 5));
         end
      end

      wait_drained();
      if (error_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

@@ files.f @@
design/fpr_pkg.sv
design/frame_packet_reassembler_core.sv
sim/tb_frame_packet_reassembler_core.sv
